@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL. Simulation builds get the checks,
// synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: label");

// Property with an antecedent and a consequent checked in the cycle after it.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/tn_rx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tn_rx_pkg;

   // Telnet command bytes
   localparam logic [7:0] TN_SE           = 8'd240;
   localparam logic [7:0] TN_SB           = 8'd250;
   localparam logic [7:0] TN_WILL         = 8'd251;
   localparam logic [7:0] TN_WONT         = 8'd252;
   localparam logic [7:0] TN_DO           = 8'd253;
   localparam logic [7:0] TN_DONT         = 8'd254;
   localparam logic [7:0] TN_IAC          = 8'd255;
   localparam logic [7:0] TN_OPT_COM_PORT = 8'd44;

   // Result kinds
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   // Position of a byte within a three-byte reply
   typedef enum logic [1:0] {
      RPL_IAC  = 2'd0,
      RPL_VERB = 2'd1,
      RPL_OPT  = 2'd2
   } rpl_idx_type;

endpackage

`default_nettype wire

@@ design/telnet_rx_option_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Inbound telnet byte filter. Each received byte is parsed in the cycle it is
// accepted and its results go to a single result register. Plain data bytes
// (and IAC IAC as a literal 0xFF) leave as one data transaction, so the block
// takes one byte per cycle for ordinary traffic while the result channel does
// not stall. An option request answered with a reply produces three reply
// transactions (IAC, verb, option) from the result register, one per cycle
// while the result channel does not stall; the input is held off until the
// last of them is taken. Command and subnegotiation bytes produce nothing.
// The result register is handed a new item in the same cycle its last byte is
// taken. csr_wdata written with csr_write sets link_open (reset 1); with it
// low, replies are dropped while the COM-PORT flag still follows DO/DONT 44.
// req_chunk_end is carried for framing only and does not affect parsing.

`include "assert_macros.svh"

module telnet_rx_option_filter (
   input  wire logic       clock,
   input  wire logic       reset,
   // configuration
   input  wire logic       csr_write,
   input  wire logic       csr_wdata,
   // received bytes
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_chunk_end,
   // results
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_out_kind,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last,
   output logic            rsp_comport_on
);

   typedef enum logic [2:0] {
      ST_DATA   = 3'd0,
      ST_IAC    = 3'd1,
      ST_OPT    = 3'd2,
      ST_SB     = 3'd3,
      ST_SB_IAC = 3'd4
   } state_type;

   state_type               state_ff, state_in;
   logic [7:0]              verb_ff, verb_in;
   logic                    comport_ff, comport_in;
   logic                    link_open_ff;

   // result register
   logic                    rvalid_ff;
   logic                    rkind_ff;
   logic [7:0]              rverb_ff;
   logic [7:0]              rbyte_ff;
   logic                    rflag_ff;
   tn_rx_pkg::rpl_idx_type  ridx_ff;

   logic                    in_fire, out_fire;
   logic                    load, load_kind;
   logic [7:0]              load_verb;
   logic                    reply_req;
   logic [7:0]              reply_verb;
   logic                    chunk_seen;

   // chunk markers carry no parsing meaning
   assign chunk_seen = req_chunk_end;

   // handshakes
   assign out_fire  = rvalid_ff && !rsp_stall;
   assign req_stall = rvalid_ff && !(out_fire && rsp_out_last);
   assign in_fire   = req_valid && !req_stall;

   // option request decode
   always_comb begin
      reply_req  = 1'b0;
      reply_verb = tn_rx_pkg::TN_WONT;
      comport_in = comport_ff;
      if (req_rx_byte == tn_rx_pkg::TN_OPT_COM_PORT) begin
         if (verb_ff == tn_rx_pkg::TN_DO) begin
            comport_in = 1'b1;
            reply_req  = 1'b1;
            reply_verb = tn_rx_pkg::TN_WILL;
         end else if (verb_ff == tn_rx_pkg::TN_DONT) begin
            comport_in = 1'b0;
         end
      end else if (verb_ff == tn_rx_pkg::TN_DO) begin
         reply_req  = 1'b1;
         reply_verb = tn_rx_pkg::TN_WONT;
      end else if (verb_ff == tn_rx_pkg::TN_WILL) begin
         reply_req  = 1'b1;
         reply_verb = tn_rx_pkg::TN_DONT;
      end
   end

   // byte parser
   always_comb begin
      state_in  = state_ff;
      verb_in   = verb_ff;
      load      = 1'b0;
      load_kind = tn_rx_pkg::KIND_DATA;
      load_verb = reply_verb;
      unique case (state_ff)
         ST_IAC: begin
            if (req_rx_byte == tn_rx_pkg::TN_IAC) begin
               state_in = ST_DATA;
               load     = 1'b1;
            end else if (req_rx_byte == tn_rx_pkg::TN_WILL
                         || req_rx_byte == tn_rx_pkg::TN_WONT
                         || req_rx_byte == tn_rx_pkg::TN_DO
                         || req_rx_byte == tn_rx_pkg::TN_DONT) begin
               verb_in  = req_rx_byte;
               state_in = ST_OPT;
            end else if (req_rx_byte == tn_rx_pkg::TN_SB) begin
               state_in = ST_SB;
            end else begin
               state_in = ST_DATA;
            end
         end
         ST_OPT: begin
            state_in  = ST_DATA;
            load      = reply_req && link_open_ff;
            load_kind = tn_rx_pkg::KIND_REPLY;
         end
         ST_SB: begin
            if (req_rx_byte == tn_rx_pkg::TN_IAC) begin
               state_in = ST_SB_IAC;
            end
         end
         ST_SB_IAC: begin
            state_in = (req_rx_byte == tn_rx_pkg::TN_SE) ? ST_DATA : ST_SB;
         end
         default: begin
            // data state, and any unused code
            if (req_rx_byte == tn_rx_pkg::TN_IAC) begin
               state_in = ST_IAC;
            end else begin
               state_in = ST_DATA;
               load     = 1'b1;
            end
         end
      endcase
   end

   // parser state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DATA;
         verb_ff      <= 8'd0;
         comport_ff   <= 1'b0;
         link_open_ff <= 1'b1;
      end else begin
         if (csr_write) begin
            link_open_ff <= csr_wdata;
         end
         if (in_fire) begin
            state_ff <= state_in;
            verb_ff  <= verb_in;
            if (state_ff == ST_OPT) begin
               comport_ff <= comport_in;
            end
         end
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
         ridx_ff   <= tn_rx_pkg::RPL_IAC;
      end else if (in_fire && load) begin
         rvalid_ff <= 1'b1;
         ridx_ff   <= tn_rx_pkg::RPL_IAC;
      end else if (out_fire) begin
         if (rsp_out_last) begin
            rvalid_ff <= 1'b0;
         end else begin
            ridx_ff <= tn_rx_pkg::rpl_idx_type'(ridx_ff + 2'd1);
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (in_fire && load) begin
         rkind_ff <= load_kind;
         rverb_ff <= load_verb;
         rbyte_ff <= req_rx_byte;
         rflag_ff <= (state_ff == ST_OPT) ? comport_in : comport_ff;
      end
   end

   // output selection
   always_comb begin
      rsp_out_byte = rbyte_ff;
      rsp_out_last = 1'b1;
      if (rkind_ff == tn_rx_pkg::KIND_REPLY) begin
         unique case (ridx_ff)
            tn_rx_pkg::RPL_IAC: begin
               rsp_out_byte = tn_rx_pkg::TN_IAC;
               rsp_out_last = 1'b0;
            end
            tn_rx_pkg::RPL_VERB: begin
               rsp_out_byte = rverb_ff;
               rsp_out_last = 1'b0;
            end
            default: begin
               rsp_out_byte = rbyte_ff;
               rsp_out_last = 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid      = rvalid_ff;
   assign rsp_out_kind   = rkind_ff;
   assign rsp_comport_on = rflag_ff;

   // a reply is delivered as three back-to-back reply bytes
   `ASSERT_NEXT(a_reply_contig, clock, reset,
      rsp_valid && !rsp_stall && rsp_out_kind && !rsp_out_last,
      rsp_valid && rsp_out_kind)

   // data transactions are always single
   `ASSERT_ALWAYS(a_data_single, clock, reset,
      !(rsp_valid && !rsp_out_kind) || rsp_out_last)

   // the COM-PORT flag only moves on an accepted byte
   `ASSERT_NEXT(a_flag_hold, clock, reset, !in_fire, $stable(comport_ff))

   // the chunk marker is a clean bit whenever a byte is offered
   `ASSERT_ALWAYS(a_chunk_known, clock, reset, !req_valid || !$isunknown(chunk_seen))

endmodule

`default_nettype wire

@@ verif/telnet_rx_option_filter_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the telnet receive filter, predicts the results of
// every accepted byte and compares them in order against the result channel.
module telnet_rx_option_filter_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write,
   input  wire logic       csr_wdata,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic       rsp_out_kind,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_out_last,
   input  wire logic       rsp_comport_on,
   output int              pending,
   output int              fail_count
);

   typedef enum logic [2:0] {
      ST_DATA   = 3'd0,
      ST_IAC    = 3'd1,
      ST_OPT    = 3'd2,
      ST_SB     = 3'd3,
      ST_SB_IAC = 3'd4
   } parse_state_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic       last;
      logic       comport;
   } rx_result_type;

   rx_result_type   expected_out[$];
   parse_state_type parse_st;
   logic [7:0]      held_verb;
   logic            comport_flag;
   logic            link_open;

   function automatic void push_result(input logic kind, input logic [7:0] value,
                                       input logic last);
      rx_result_type r;
      r.kind    = kind;
      r.value   = value;
      r.last    = last;
      r.comport = comport_flag;
      expected_out.push_back(r);
   endfunction

   // three-byte answer to the server, dropped while the link is closed
   function automatic void push_reply(input logic [7:0] verb, input logic [7:0] opt);
      if (link_open) begin
         push_result(tn_rx_pkg::KIND_REPLY, tn_rx_pkg::TN_IAC, 1'b0);
         push_result(tn_rx_pkg::KIND_REPLY, verb, 1'b0);
         push_result(tn_rx_pkg::KIND_REPLY, opt, 1'b1);
      end
   endfunction

   // one received byte through the IAC parser
   function automatic void parse_rx_byte(input logic [7:0] c);
      case (parse_st)
         ST_IAC: begin
            if (c == tn_rx_pkg::TN_IAC) begin
               parse_st = ST_DATA;
               push_result(tn_rx_pkg::KIND_DATA, c, 1'b1);
            end else if (c inside {tn_rx_pkg::TN_WILL, tn_rx_pkg::TN_WONT,
                                   tn_rx_pkg::TN_DO, tn_rx_pkg::TN_DONT}) begin
               held_verb = c;
               parse_st  = ST_OPT;
            end else if (c == tn_rx_pkg::TN_SB) begin
               parse_st = ST_SB;
            end else begin
               // two-byte command, dropped
               parse_st = ST_DATA;
            end
         end
         ST_OPT: begin
            parse_st = ST_DATA;
            if (c == tn_rx_pkg::TN_OPT_COM_PORT) begin
               if (held_verb == tn_rx_pkg::TN_DO) begin
                  comport_flag = 1'b1;
                  push_reply(tn_rx_pkg::TN_WILL, tn_rx_pkg::TN_OPT_COM_PORT);
               end else if (held_verb == tn_rx_pkg::TN_DONT) begin
                  comport_flag = 1'b0;
               end
            end else if (held_verb == tn_rx_pkg::TN_DO) begin
               push_reply(tn_rx_pkg::TN_WONT, c);
            end else if (held_verb == tn_rx_pkg::TN_WILL) begin
               push_reply(tn_rx_pkg::TN_DONT, c);
            end
         end
         ST_SB: begin
            if (c == tn_rx_pkg::TN_IAC) parse_st = ST_SB_IAC;
         end
         ST_SB_IAC: begin
            // anything but SE keeps the subnegotiation open
            parse_st = (c == tn_rx_pkg::TN_SE) ? ST_DATA : ST_SB;
         end
         default: begin
            if (c == tn_rx_pkg::TN_IAC) begin
               parse_st = ST_IAC;
            end else begin
               parse_st = ST_DATA;
               push_result(tn_rx_pkg::KIND_DATA, c, 1'b1);
            end
         end
      endcase
   endfunction

   // csr first, then the result leaving, then the byte entering
   always @(posedge clock) begin : watch
      rx_result_type exp_r;
      if (reset) begin
         parse_st     = ST_DATA;
         held_verb    = 8'd0;
         comport_flag = 1'b0;
         link_open    = 1'b1;
         expected_out.delete();
      end else begin
         if (csr_write) link_open = csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            if (expected_out.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t unexpected result: kind=%0d byte=%02h last=%0d com=%0d",
                           $time, rsp_out_kind, rsp_out_byte, rsp_out_last,
                           rsp_comport_on);
               fail_count = fail_count + 1;
            end else begin
               exp_r = expected_out.pop_front();
               if (rsp_out_kind !== exp_r.kind || rsp_out_byte !== exp_r.value ||
                   rsp_out_last !== exp_r.last || rsp_comport_on !== exp_r.comport) begin
                  if (fail_count < 10)
                     $display("%0t mismatch: exp kind=%0d byte=%02h last=%0d com=%0d, %s",
                              $time, exp_r.kind, exp_r.value, exp_r.last, exp_r.comport,
                              $sformatf("got kind=%0d byte=%02h last=%0d com=%0d",
                                        rsp_out_kind, rsp_out_byte, rsp_out_last,
                                        rsp_comport_on));
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) parse_rx_byte(req_rx_byte);
      end
      pending = expected_out.size();
   end

endmodule

@@ verif/telnet_rx_option_filter_tb.sv @@
`timescale 1ns / 1ps

module telnet_rx_option_filter_tb;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write = 1'b0;
   logic       csr_wdata = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'd0;
   logic       req_chunk_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_out_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       rsp_comport_on;

   int pending;
   int fail_count;
   int send_idle_pct = 7;
   int stall_pct = 59;

   telnet_rx_option_filter u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .req_chunk_end  (req_chunk_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .rsp_comport_on (rsp_comport_on)
   );

   telnet_rx_option_filter_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .rsp_comport_on (rsp_comport_on),
      .pending        (pending),
      .fail_count     (fail_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // random backpressure on the result channel
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // one received byte; valid stays up until the transaction is taken
   task automatic push_rx_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_rx_byte   <= b;
      req_chunk_end <= 1'($urandom_range(1));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and let every expected result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_link_open(input logic v);
      wait_idle();
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // mostly well-formed telnet sequences with random content, some noise
   task automatic send_random_sequence(output int counted);
      int         pick;
      int         len;
      logic [7:0] verb;
      pick = $urandom_range(99);
      if (pick < 40) begin
         push_rx_byte(8'($urandom_range(254)));
         counted = 1;
      end else if (pick < 48) begin
         push_rx_byte(tn_rx_pkg::TN_IAC);
         push_rx_byte(tn_rx_pkg::TN_IAC);
         counted = 2;
      end else if (pick < 73) begin
         verb = tn_rx_pkg::TN_WILL + 8'($urandom_range(3));
         push_rx_byte(tn_rx_pkg::TN_IAC);
         push_rx_byte(verb);
         push_rx_byte($urandom_range(1) ? tn_rx_pkg::TN_OPT_COM_PORT
                                        : 8'($urandom_range(255)));
         counted = 3;
      end else if (pick < 83) begin
         // subnegotiation; the payload bytes are swallowed
         len = $urandom_range(1, 6);
         push_rx_byte(tn_rx_pkg::TN_IAC);
         push_rx_byte(tn_rx_pkg::TN_SB);
         repeat (len) push_rx_byte(8'($urandom_range(255)));
         push_rx_byte(tn_rx_pkg::TN_IAC);
         push_rx_byte(tn_rx_pkg::TN_SE);
         counted = 4 + len;
      end else if (pick < 90) begin
         push_rx_byte(tn_rx_pkg::TN_IAC);
         push_rx_byte(8'($urandom_range(255)));
         counted = 2;
      end else begin
         push_rx_byte(8'($urandom_range(255)));
         counted = 1;
      end
   endtask

   task automatic run_random(input int items);
      int sent;
      int n;
      sent = 0;
      while (sent < items) begin
         send_random_sequence(n);
         sent = sent + n;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_link_open(1'b1);

      // directed: data extremes, escaped IAC, the verbs DO, WILL and DONT, options and commands
      push_rx_byte(8'h00);
      push_rx_byte(tn_rx_pkg::TN_IAC); push_rx_byte(tn_rx_pkg::TN_IAC);
      push_rx_byte(tn_rx_pkg::TN_IAC); push_rx_byte(tn_rx_pkg::TN_DO);
      push_rx_byte(tn_rx_pkg::TN_OPT_COM_PORT);
      push_rx_byte(tn_rx_pkg::TN_IAC); push_rx_byte(tn_rx_pkg::TN_WILL);
      push_rx_byte(8'h03);
      push_rx_byte(tn_rx_pkg::TN_IAC); push_rx_byte(tn_rx_pkg::TN_DO);
      push_rx_byte(8'hFF);
      push_rx_byte(tn_rx_pkg::TN_IAC); push_rx_byte(tn_rx_pkg::TN_DONT);
      push_rx_byte(tn_rx_pkg::TN_OPT_COM_PORT);
      push_rx_byte(tn_rx_pkg::TN_IAC); push_rx_byte(8'd241);
      // IAC followed by a non-SE byte stays inside the subnegotiation
      push_rx_byte(tn_rx_pkg::TN_IAC); push_rx_byte(tn_rx_pkg::TN_SB);
      push_rx_byte(8'h07);
      push_rx_byte(tn_rx_pkg::TN_IAC); push_rx_byte(8'h01);
      push_rx_byte(tn_rx_pkg::TN_IAC); push_rx_byte(tn_rx_pkg::TN_SE);
      push_rx_byte(8'hFE);

      // link closed: replies dropped, flag still tracked
      set_link_open(1'b0);
      run_random(60);

      send_idle_pct = 59;
      stall_pct     = 7;
      set_link_open(1'b1);
      run_random(60);

      send_idle_pct = 0;
      stall_pct     = 0;
      set_link_open(1'b1);
      run_random(32);
      set_link_open(1'b0);
      run_random(32);

      wait_idle();
      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/tn_rx_pkg.sv
design/telnet_rx_option_filter.sv
verif/telnet_rx_option_filter_checker.sv
verif/telnet_rx_option_filter_tb.sv
